FILE: hw/rtl/qcmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qcmd_pkg
// Shared types, constants and helpers for the quadrature counter and
// motor drive block.
// ----------------------------------------------------------------------------
package qcmd_pkg;

    // block dimensions
    localparam int NUM_ENCODERS = 6;
    localparam int NUM_MOTORS   = 3;
    localparam int COUNT_WIDTH  = 16;

    // fixed field widths
    localparam int FIELD_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int WDOG_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;
    localparam int INDEX_W   = 3;

    // number of counters that have a preset field
    localparam int PRESET_NUM = 6;

    // duty midpoint and the rounding bias added to the Q8 product
    localparam logic [FIELD_W-1:0] DUTY_MID  = 16'h8000;
    localparam logic signed [33:0] DUTY_BIAS = 34'sd8388736;

    // host command that presets the counters
    localparam logic signed [FIELD_W-1:0] HOST_CMD_PRESET = 16'sd1;

    // transition table, indexed by {previous state, current state}
    // where a state is {A, B}; marks the entries that step up or down
    localparam logic [15:0] STEP_UP_MASK = 16'h4182;
    localparam logic [15:0] STEP_DN_MASK = 16'h2814;

    // item kinds
    typedef enum logic [1:0] {
        ACT_PIN    = 2'd0,
        ACT_HOST   = 2'd1,
        ACT_BUTTON = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_GAIN      = 2'd0,
        CFG_WATCHDOG_TICKS = 2'd1,
        CFG_COUNT_REVERSE  = 2'd2
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic [GAIN_W-1:0] duty_gain;
        logic [WDOG_W-1:0] watchdog_ticks;
        logic              count_reverse;
    } t_cfg;

    // control for the update of the state by one beat
    typedef struct packed {
        logic    fire;
        t_action action;
        logic    preset;
    } t_step_ctl;

    typedef logic signed [COUNT_WIDTH-1:0] t_count;
    typedef logic signed [FIELD_W-1:0]     t_field;

    // preset field to counter width, sign extended or truncated
    function automatic t_count qcmd_preset(input t_field v);
        return COUNT_WIDTH'(v);
    endfunction

    // counter to the 16-bit report, sign extended or truncated
    function automatic t_field qcmd_count_out(input t_count c);
        return FIELD_W'(c);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/quadrature_counter_motor_drive.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_counter_motor_drive
// Six-channel x4 quadrature counter with a host-driven motor current
// interface, one result beat per input beat.
// ----------------------------------------------------------------------------
// Pipeline: an accepted beat passes the input register, then the result
// register, which holds its result.
// Throughput: one beat per cycle unless the result side stalls; the per-motor
// duty multiply-adds and the counter update sit in the one stage between them.
// Reset is synchronous and active low: counters, flags, watchdog and valids
// clear, duties go to the midpoint and configuration takes its reset values.
module quadrature_counter_motor_drive (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [qcmd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [qcmd_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [1:0]                            i_action,
    input  wire logic [qcmd_pkg::INDEX_W-1:0]          i_encoder_index,
    input  wire logic                                  i_encoder_phase,
    input  wire logic                                  i_pin_level,
    input  wire logic signed [qcmd_pkg::FIELD_W-1:0]   i_current_a,
    input  wire logic signed [qcmd_pkg::FIELD_W-1:0]   i_current_b,
    input  wire logic signed [qcmd_pkg::FIELD_W-1:0]   i_current_c,
    input  wire logic signed [qcmd_pkg::FIELD_W-1:0]   i_host_command,
    input  wire logic signed [qcmd_pkg::FIELD_W-1:0]   i_preset_0,
    input  wire logic signed [qcmd_pkg::FIELD_W-1:0]   i_preset_1,
    input  wire logic signed [qcmd_pkg::FIELD_W-1:0]   i_preset_2,
    // result channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [qcmd_pkg::FIELD_W-1:0]        o_count_0,
    output logic signed [qcmd_pkg::FIELD_W-1:0]        o_count_1,
    output logic signed [qcmd_pkg::FIELD_W-1:0]        o_count_2,
    output logic signed [qcmd_pkg::FIELD_W-1:0]        o_count_3,
    output logic signed [qcmd_pkg::FIELD_W-1:0]        o_count_4,
    output logic signed [qcmd_pkg::FIELD_W-1:0]        o_count_5,
    output logic                                       o_calibration_request,
    output logic [qcmd_pkg::FIELD_W-1:0]               o_duty_a,
    output logic [qcmd_pkg::FIELD_W-1:0]               o_duty_b,
    output logic [qcmd_pkg::FIELD_W-1:0]               o_duty_c,
    output logic                                       o_drive_enable
);
    import qcmd_pkg::*;

    localparam int NUM_CNT_OUT  = 6;
    localparam int NUM_DUTY_OUT = 3;

    // configuration registers
    t_cfg r_cfg;

    // input register
    logic               r_in_valid;
    t_action            r_action;
    logic [INDEX_W-1:0] r_index;
    logic               r_phase;
    logic               r_level;
    t_field             r_cur  [NUM_DUTY_OUT];
    t_field             r_cmd;
    t_field             r_pre  [PRESET_NUM];

    // result register
    logic               r_out_valid;
    t_field             r_cnt_out [NUM_CNT_OUT];
    logic [FIELD_W-1:0] r_duty_out[NUM_DUTY_OUT];
    logic               r_cal_out;
    logic               r_en_out;

    logic               w_accept;
    logic               w_fire;
    t_step_ctl          w_ctl;
    t_field             w_currents[NUM_MOTORS];
    t_count             w_counts  [NUM_ENCODERS];
    logic [FIELD_W-1:0] w_duties  [NUM_MOTORS];
    logic               w_enable;
    logic               w_button;
    t_field             w_cnt_rep [NUM_CNT_OUT];
    logic [FIELD_W-1:0] w_duty_rep[NUM_DUTY_OUT];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_gain      <= GAIN_W'(2237);
            r_cfg.watchdog_ticks <= WDOG_W'(500);
            r_cfg.count_reverse  <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DUTY_GAIN:      r_cfg.duty_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_WATCHDOG_TICKS: r_cfg.watchdog_ticks <= i_cfg_data[WDOG_W-1:0];
                CFG_COUNT_REVERSE:  r_cfg.count_reverse  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // handshake: a beat moves on when the result register is free or leaving
    assign w_fire     = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= t_action'(i_action);
            r_index  <= i_encoder_index;
            r_phase  <= i_encoder_phase;
            r_level  <= i_pin_level;
            r_cur[0] <= i_current_a;
            r_cur[1] <= i_current_b;
            r_cur[2] <= i_current_c;
            r_cmd    <= i_host_command;
            r_pre[0] <= i_preset_0;
            r_pre[1] <= i_preset_1;
            r_pre[2] <= i_preset_2;
            r_pre[3] <= i_current_a;
            r_pre[4] <= i_current_b;
            r_pre[5] <= i_current_c;
        end
    end

    // step control for the state units
    always_comb begin
        w_ctl.fire   = w_fire;
        w_ctl.action = r_action;
        w_ctl.preset = (r_cmd == HOST_CMD_PRESET);
    end

    for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_cur
        assign w_currents[m] = r_cur[m];
    end

    qcmd_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_reverse (r_cfg.count_reverse),
        .i_index   (r_index),
        .i_phase   (r_phase),
        .i_level   (r_level),
        .i_presets (r_pre),
        .o_counts  (w_counts)
    );

    qcmd_drive u_drive (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_cfg      (r_cfg),
        .i_currents (w_currents),
        .o_duties   (w_duties),
        .o_enable   (w_enable),
        .o_button   (w_button)
    );

    // report values, missing channels read zero and missing motors midpoint
    for (genvar c = 0; c < NUM_CNT_OUT; c++) begin : g_cnt_rep
        if (c < NUM_ENCODERS) begin : g_have
            assign w_cnt_rep[c] = qcmd_count_out(w_counts[c]);
        end else begin : g_none
            assign w_cnt_rep[c] = '0;
        end
    end
    for (genvar d = 0; d < NUM_DUTY_OUT; d++) begin : g_duty_rep
        if (d < NUM_MOTORS) begin : g_have
            assign w_duty_rep[d] = w_duties[d];
        end else begin : g_none
            assign w_duty_rep[d] = DUTY_MID;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_cnt_out  <= w_cnt_rep;
            r_duty_out <= w_duty_rep;
            r_cal_out  <= w_button;
            r_en_out   <= w_enable;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_count_0             = r_cnt_out[0];
    assign o_count_1             = r_cnt_out[1];
    assign o_count_2             = r_cnt_out[2];
    assign o_count_3             = r_cnt_out[3];
    assign o_count_4             = r_cnt_out[4];
    assign o_count_5             = r_cnt_out[5];
    assign o_calibration_request = r_cal_out;
    assign o_duty_a              = r_duty_out[0];
    assign o_duty_b              = r_duty_out[1];
    assign o_duty_c              = r_duty_out[2];
    assign o_drive_enable        = r_en_out;

`ifndef SYNTH
    // the input side only stalls with a beat waiting behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled without a waiting beat");
    // a beat that moves on always shows up as a result
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("fired beat produced no result");
    // a reported disabled drive reports midpoint duties
    a_off_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_drive_enable) |->
            (o_duty_a == DUTY_MID && o_duty_b == DUTY_MID && o_duty_c == DUTY_MID))
        else $error("disabled drive reports non-midpoint duty");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/qcmd_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qcmd_decoder
// Bank of x4 quadrature channels: pin levels, last phase state and
// position counters, with preset from the host.
// ----------------------------------------------------------------------------
module qcmd_decoder (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire qcmd_pkg::t_step_ctl                    i_ctl,
    input  wire logic                                   i_reverse,
    input  wire logic [qcmd_pkg::INDEX_W-1:0]           i_index,
    input  wire logic                                   i_phase,
    input  wire logic                                   i_level,
    input  wire qcmd_pkg::t_field                       i_presets [qcmd_pkg::PRESET_NUM],
    output qcmd_pkg::t_count                            o_counts  [qcmd_pkg::NUM_ENCODERS]
);
    import qcmd_pkg::*;

    logic [1:0] r_pins [NUM_ENCODERS];
    logic [1:0] r_last [NUM_ENCODERS];
    logic       r_seen [NUM_ENCODERS];
    t_count     r_count[NUM_ENCODERS];
    logic [1:0] n_pins [NUM_ENCODERS];
    logic [1:0] n_last [NUM_ENCODERS];
    logic       n_seen [NUM_ENCODERS];
    t_count     n_count[NUM_ENCODERS];

    for (genvar g = 0; g < NUM_ENCODERS; g++) begin : g_chan
        logic       w_hit;
        logic [1:0] w_cur;
        logic [1:0] w_prev;
        logic [3:0] w_idx;
        logic       w_up;
        logic       w_dn;
        t_count     w_preset;

        // preset source, counters past the preset fields keep their count
        if (g < PRESET_NUM) begin : g_pre
            assign w_preset = qcmd_preset(i_presets[g]);
        end else begin : g_nopre
            assign w_preset = r_count[g];
        end

        // new pin levels, phase A is the high bit of the state
        always_comb begin
            w_hit = i_ctl.fire && (i_ctl.action == ACT_PIN)
                    && (i_index == INDEX_W'(g));
            w_cur = r_pins[g];
            if (i_phase) begin
                w_cur[0] = i_level;
            end else begin
                w_cur[1] = i_level;
            end
            w_prev = r_seen[g] ? r_last[g] : w_cur;
            w_idx  = {w_prev, w_cur};
            w_up   = i_reverse ? STEP_UP_MASK[w_idx] : STEP_DN_MASK[w_idx];
            w_dn   = i_reverse ? STEP_DN_MASK[w_idx] : STEP_UP_MASK[w_idx];
        end

        // next channel state
        always_comb begin
            n_pins[g]  = r_pins[g];
            n_last[g]  = r_last[g];
            n_seen[g]  = r_seen[g];
            n_count[g] = r_count[g];
            if (w_hit) begin
                n_pins[g] = w_cur;
                n_last[g] = w_cur;
                n_seen[g] = 1'b1;
                if (w_up) begin
                    n_count[g] = r_count[g] + t_count'(1);
                end else if (w_dn) begin
                    n_count[g] = r_count[g] - t_count'(1);
                end
            end else if (i_ctl.fire && (i_ctl.action == ACT_HOST) && i_ctl.preset) begin
                n_count[g] = w_preset;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pins[g]  <= '0;
                r_last[g]  <= '0;
                r_seen[g]  <= 1'b0;
                r_count[g] <= '0;
            end else begin
                r_pins[g]  <= n_pins[g];
                r_last[g]  <= n_last[g];
                r_seen[g]  <= n_seen[g];
                r_count[g] <= n_count[g];
            end
        end

        assign o_counts[g] = n_count[g];
    end

`ifndef SYNTH
    for (genvar a = 0; a < NUM_ENCODERS; a++) begin : g_chk
        // a channel that never moved has recorded no state
        a_unseen_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            !r_seen[a] |-> (r_last[a] == 2'b00 && r_pins[a] == 2'b00))
            else $error("unseen channel holds a phase state");
        // after a pin beat the last state follows the pins
        a_last_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_seen[a] |-> (r_last[a] == r_pins[a]))
            else $error("last phase state differs from pin levels");
    end
    // a pin beat for channel 0 marks it as seen
    a_hit_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.fire && i_ctl.action == ACT_PIN && i_index == '0) |=> r_seen[0])
        else $error("channel not marked after pin beat");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/qcmd_drive.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qcmd_drive
// Motor drive state: current to duty scaling with saturation, drive
// enable, tick watchdog and the calibration flag.
// ----------------------------------------------------------------------------
module qcmd_drive (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire qcmd_pkg::t_step_ctl                i_ctl,
    input  wire qcmd_pkg::t_cfg                     i_cfg,
    input  wire qcmd_pkg::t_field                   i_currents [qcmd_pkg::NUM_MOTORS],
    output logic [qcmd_pkg::FIELD_W-1:0]            o_duties   [qcmd_pkg::NUM_MOTORS],
    output logic                                    o_enable,
    output logic                                    o_button
);
    import qcmd_pkg::*;

    logic [FIELD_W-1:0] r_duty [NUM_MOTORS];
    logic [FIELD_W-1:0] n_duty [NUM_MOTORS];
    logic [FIELD_W-1:0] w_scaled[NUM_MOTORS];
    logic [WDOG_W-1:0]  r_wdog;
    logic [WDOG_W-1:0]  n_wdog;
    logic               r_enable;
    logic               n_enable;
    logic               r_button;
    logic               n_button;

    // milliamps times gain in Q8, rounded and clamped to the duty range
    for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_scale
        logic signed [32:0] w_prod;
        logic signed [33:0] w_sum;
        always_comb begin
            w_prod = 33'(i_currents[m]) * $signed(33'({1'b0, i_cfg.duty_gain}));
            w_sum  = 34'(w_prod) + DUTY_BIAS;
            if (w_sum[33]) begin
                w_scaled[m] = '0;
            end else if (|w_sum[32:24]) begin
                w_scaled[m] = '1;
            end else begin
                w_scaled[m] = w_sum[23:8];
            end
        end
    end

    // next drive state
    always_comb begin
        n_duty   = r_duty;
        n_wdog   = r_wdog;
        n_enable = r_enable;
        n_button = r_button;
        if (i_ctl.fire) begin
            unique case (i_ctl.action)
                ACT_HOST: begin
                    n_enable = 1'b1;
                    n_wdog   = i_cfg.watchdog_ticks;
                    if (i_ctl.preset) begin
                        n_button = 1'b0;
                        for (int m = 0; m < NUM_MOTORS; m++) n_duty[m] = DUTY_MID;
                    end else begin
                        n_duty = w_scaled;
                    end
                end
                ACT_BUTTON: begin
                    n_button = 1'b1;
                end
                ACT_TICK: begin
                    if (r_enable) begin
                        if (r_wdog <= WDOG_W'(1)) begin
                            n_wdog   = '0;
                            n_enable = 1'b0;
                            for (int m = 0; m < NUM_MOTORS; m++) n_duty[m] = DUTY_MID;
                        end else begin
                            n_wdog = r_wdog - WDOG_W'(1);
                        end
                    end
                end
                ACT_PIN: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NUM_MOTORS; m++) r_duty[m] <= DUTY_MID;
            r_wdog   <= '0;
            r_enable <= 1'b0;
            r_button <= 1'b0;
        end else begin
            r_duty   <= n_duty;
            r_wdog   <= n_wdog;
            r_enable <= n_enable;
            r_button <= n_button;
        end
    end

    assign o_duties = n_duty;
    assign o_enable = n_enable;
    assign o_button = n_button;

`ifndef SYNTH
    // a running watchdog implies the drive is enabled
    a_wdog_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wdog != '0) |-> r_enable)
        else $error("watchdog running while drive disabled");
    // a disabled drive holds the first duty at the midpoint
    a_off_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enable |-> (r_duty[0] == DUTY_MID))
        else $error("duty off midpoint while drive disabled");
    // a host beat enables the drive
    a_host_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.fire && i_ctl.action == ACT_HOST) |=> r_enable)
        else $error("host beat did not enable drive");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quadrature counter and motor drive block.
// Drives pin-change, host, button and tick beats with random gaps and
// result stalls, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
    import qcmd_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_BEATS     = 275;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 80;
    localparam int NUM_FIELDS      = 11;

    // one input beat
    typedef struct packed {
        t_action              action;
        logic [INDEX_W-1:0]   enc_index;
        logic                 enc_phase;
        logic                 pin_level;
        t_field               cur_a;
        t_field               cur_b;
        t_field               cur_c;
        t_field               command;
        t_field               preset_0;
        t_field               preset_1;
        t_field               preset_2;
    } t_beat;

    // one result beat
    typedef struct packed {
        t_field               count_0;
        t_field               count_1;
        t_field               count_2;
        t_field               count_3;
        t_field               count_4;
        t_field               count_5;
        logic                 cal_req;
        logic [FIELD_W-1:0]   duty_a;
        logic [FIELD_W-1:0]   duty_b;
        logic [FIELD_W-1:0]   duty_c;
        logic                 drive_en;
    } t_status;

    typedef logic [FIELD_W-1:0] t_field_vec [NUM_FIELDS];

    // ------------------------------------------------------------------------
    // scoreboard: tracks encoder, drive and watchdog state, holds the
    // expected status beats in order
    // ------------------------------------------------------------------------
    class qcmd_scoreboard;
        logic [GAIN_W-1:0]  duty_gain;
        logic [WDOG_W-1:0]  wdog_reload;
        logic               count_reverse;
        logic [1:0]         pin_state [NUM_ENCODERS];
        logic [1:0]         last_state [NUM_ENCODERS];
        bit                 state_seen [NUM_ENCODERS];
        logic [15:0]        position [NUM_ENCODERS];
        bit                 cal_flag;
        logic [15:0]        duty [NUM_MOTORS];
        bit                 drive_on;
        logic [WDOG_W-1:0]  wdog_left;
        int                 step_delta [16];
        string              field_name [NUM_FIELDS];
        t_status            status_q [$];
        int                 mismatches;
        int                 checked;
        int                 host_beats;
        int                 expiries;

        function new();
            step_delta = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};
            field_name = '{"count_0", "count_1", "count_2", "count_3", "count_4",
                           "count_5", "calibration_request", "duty_a", "duty_b",
                           "duty_c", "drive_enable"};
            duty_gain     = 16'd2237;
            wdog_reload   = 20'd500;
            count_reverse = 1'b1;
            for (int i = 0; i < NUM_ENCODERS; i++) begin
                pin_state[i]  = 2'b00;
                last_state[i] = 2'b00;
                state_seen[i] = 1'b0;
                position[i]   = '0;
            end
            cal_flag  = 1'b0;
            foreach (duty[i]) duty[i] = DUTY_MID;
            drive_on  = 1'b0;
            wdog_left = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] d);
            case (idx)
                CFG_DUTY_GAIN:      duty_gain     = d[GAIN_W-1:0];
                CFG_WATCHDOG_TICKS: wdog_reload   = d[WDOG_W-1:0];
                CFG_COUNT_REVERSE:  count_reverse = d[0];
                default: ;
            endcase
        endfunction

        // milliamps to duty, Q8 gain, round half up, saturate
        function logic [15:0] current_to_duty(t_field ma);
            longint prod;
            prod = longint'(ma) * longint'(duty_gain) + 64'sd8388736;
            if (prod < 0)
                return 16'd0;
            prod = prod / 256;
            if (prod > 65535)
                return 16'hFFFF;
            return 16'(prod);
        endfunction

        // apply one accepted beat and queue the status it produces
        function void note_beat(t_beat b);
            int       ch;
            int       delta;
            logic [1:0] cur;
            t_status  s;
            case (b.action)
                ACT_PIN: begin
                    if (b.enc_index < NUM_ENCODERS) begin
                        ch = b.enc_index;
                        if (b.enc_phase)
                            pin_state[ch][0] = b.pin_level;
                        else
                            pin_state[ch][1] = b.pin_level;
                        cur = pin_state[ch];
                        // first change on a channel only records the state
                        if (!state_seen[ch]) begin
                            last_state[ch] = cur;
                            state_seen[ch] = 1'b1;
                        end
                        delta = step_delta[{last_state[ch], cur}];
                        if (!count_reverse)
                            delta = -delta;
                        position[ch]   = 16'(int'(position[ch]) + delta);
                        last_state[ch] = cur;
                    end
                end
                ACT_HOST: begin
                    host_beats++;
                    drive_on  = 1'b1;
                    wdog_left = wdog_reload;
                    if (b.command == HOST_CMD_PRESET) begin
                        position[0] = b.preset_0;
                        position[1] = b.preset_1;
                        position[2] = b.preset_2;
                        position[3] = b.cur_a;
                        position[4] = b.cur_b;
                        position[5] = b.cur_c;
                        cal_flag    = 1'b0;
                        foreach (duty[i]) duty[i] = DUTY_MID;
                    end else begin
                        duty[0] = current_to_duty(b.cur_a);
                        duty[1] = current_to_duty(b.cur_b);
                        duty[2] = current_to_duty(b.cur_c);
                    end
                end
                ACT_BUTTON: cal_flag = 1'b1;
                default: begin
                    // watchdog tick, only while the drive is on
                    if (drive_on) begin
                        if (wdog_left <= 1) begin
                            wdog_left = '0;
                            drive_on  = 1'b0;
                            foreach (duty[i]) duty[i] = DUTY_MID;
                            expiries++;
                        end else begin
                            wdog_left = wdog_left - 1'b1;
                        end
                    end
                end
            endcase
            s.count_0  = position[0];
            s.count_1  = position[1];
            s.count_2  = position[2];
            s.count_3  = position[3];
            s.count_4  = position[4];
            s.count_5  = position[5];
            s.cal_req  = cal_flag;
            s.duty_a   = duty[0];
            s.duty_b   = duty[1];
            s.duty_c   = duty[2];
            s.drive_en = drive_on;
            status_q.push_back(s);
        endfunction

        function t_field_vec as_fields(t_status s);
            return '{s.count_0, s.count_1, s.count_2, s.count_3, s.count_4,
                     s.count_5, {15'd0, s.cal_req}, s.duty_a, s.duty_b,
                     s.duty_c, {15'd0, s.drive_en}};
        endfunction

        // compare one result beat with the oldest expected status
        function void check_status(t_status got);
            t_field_vec exp_f;
            t_field_vec got_f;
            if (status_q.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected", $time);
                return;
            end
            exp_f = as_fields(status_q.pop_front());
            got_f = as_fields(got);
            checked++;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                if (got_f[i] !== exp_f[i]) begin
                    mismatches++;
                    $display("%0t: %s expected 'h%h got 'h%h",
                             $time, field_name[i], exp_f[i], got_f[i]);
                end
            end
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block instance
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;
    logic                  in_valid = 1'b0;
    t_beat                 drv = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    t_field                count_0, count_1, count_2, count_3, count_4, count_5;
    logic                  cal_req;
    logic [FIELD_W-1:0]    duty_a, duty_b, duty_c;
    logic                  drive_en;

    int                    send_idle_pct = 0;
    int                    stall_pct = 0;
    bit                    pressure_on = 1'b0;
    int                    hold_left = 0;
    bit                    held_once = 1'b0;
    int                    long_holds = 0;
    int                    beats_sent = 0;
    int                    cycle_count = 0;
    logic [1:0]            gen_level [NUM_ENCODERS] = '{default: 2'b00};
    bit                    gen_dir [NUM_ENCODERS] = '{default: 1'b1};

    qcmd_scoreboard sb = new();

    always #CLK_HALF clk = ~clk;

    quadrature_counter_motor_drive DUT (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_wr_en           (cfg_wr_en),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data),
        .i_in_valid            (in_valid),
        .o_in_stall            (in_stall),
        .i_action              (drv.action),
        .i_encoder_index       (drv.enc_index),
        .i_encoder_phase       (drv.enc_phase),
        .i_pin_level           (drv.pin_level),
        .i_current_a           (drv.cur_a),
        .i_current_b           (drv.cur_b),
        .i_current_c           (drv.cur_c),
        .i_host_command        (drv.command),
        .i_preset_0            (drv.preset_0),
        .i_preset_1            (drv.preset_1),
        .i_preset_2            (drv.preset_2),
        .o_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .o_count_0             (count_0),
        .o_count_1             (count_1),
        .o_count_2             (count_2),
        .o_count_3             (count_3),
        .o_count_4             (count_4),
        .o_count_5             (count_5),
        .o_calibration_request (cal_req),
        .o_duty_a              (duty_a),
        .o_duty_b              (duty_b),
        .o_duty_c              (duty_c),
        .o_drive_enable        (drive_en)
    );

    // result side stall, with long hold-offs while pressure is on
    always @(negedge clk) begin
        if (pressure_on && hold_left == 0 && (!held_once || $urandom_range(199) == 0)) begin
            hold_left = HOLD_CYCLES;
            held_once = 1'b1;
            long_holds++;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor both channels at the rising edge
    always @(posedge clk) begin
        t_status got;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got.count_0  = count_0;
                got.count_1  = count_1;
                got.count_2  = count_2;
                got.count_3  = count_3;
                got.count_4  = count_4;
                got.count_5  = count_5;
                got.cal_req  = cal_req;
                got.duty_a   = duty_a;
                got.duty_b   = duty_b;
                got.duty_c   = duty_c;
                got.drive_en = drive_en;
                sb.check_status(got);
            end
            if (in_valid && !in_stall)
                sb.note_beat(drv);
        end
    end

    // ------------------------------------------------------------------------
    // beat builders
    // ------------------------------------------------------------------------
    function automatic t_field pick_value();
        case ($urandom_range(5))
            0: return t_field'(32767 - int'($urandom_range(3)));
            1: return t_field'(-32768 + int'($urandom_range(3)));
            2: return t_field'(int'($urandom_range(600)) - 300);
            3: return t_field'(0);
            default: return t_field'($urandom);
        endcase
    endfunction

    function automatic t_beat pin_beat(int ch, bit phase, bit level);
        t_beat b;
        b = '0;
        b.action    = ACT_PIN;
        b.enc_index = INDEX_W'(ch);
        b.enc_phase = phase;
        b.pin_level = level;
        if (ch < NUM_ENCODERS) begin
            if (phase)
                gen_level[ch][0] = level;
            else
                gen_level[ch][1] = level;
        end
        return b;
    endfunction

    function automatic t_beat host_beat(t_field cmd, t_field ca, t_field cb, t_field cc,
                                        t_field p0, t_field p1, t_field p2);
        t_beat b;
        b = '0;
        b.action   = ACT_HOST;
        b.command  = cmd;
        b.cur_a    = ca;
        b.cur_b    = cb;
        b.cur_c    = cc;
        b.preset_0 = p0;
        b.preset_1 = p1;
        b.preset_2 = p2;
        return b;
    endfunction

    function automatic t_beat plain_beat(t_action act);
        t_beat b;
        b = '0;
        b.action = act;
        return b;
    endfunction

    // random beat: mostly well-formed quadrature walks, some noise
    function automatic t_beat random_beat();
        t_beat      b;
        int         roll;
        int         ch;
        logic [1:0] lv;
        b.cur_a     = pick_value();
        b.cur_b     = pick_value();
        b.cur_c     = pick_value();
        b.preset_0  = pick_value();
        b.preset_1  = pick_value();
        b.preset_2  = pick_value();
        b.command   = t_field'($urandom);
        b.enc_index = INDEX_W'($urandom);
        b.enc_phase = 1'($urandom);
        b.pin_level = 1'($urandom);
        roll = $urandom_range(99);
        if (roll < 50) begin
            b.action = ACT_PIN;
            if ($urandom_range(9) != 0) begin
                ch = $urandom_range(NUM_ENCODERS - 1);
                b.enc_index = INDEX_W'(ch);
                if ($urandom_range(19) == 0)
                    gen_dir[ch] = ~gen_dir[ch];
                if ($urandom_range(99) < 85) begin
                    // forward flips B when A equals B, backward flips A
                    lv = gen_level[ch];
                    b.enc_phase = ((lv[1] == lv[0]) == gen_dir[ch]);
                    b.pin_level = b.enc_phase ? ~lv[0] : ~lv[1];
                end
                if (b.enc_phase)
                    gen_level[ch][0] = b.pin_level;
                else
                    gen_level[ch][1] = b.pin_level;
            end else begin
                // channel with no counter behind it
                b.enc_index = INDEX_W'(NUM_ENCODERS + $urandom_range(7 - NUM_ENCODERS));
            end
        end else if (roll < 62) begin
            b.action = ACT_HOST;
            if ($urandom_range(3) == 0)
                b.command = HOST_CMD_PRESET;
            else if (b.command == HOST_CMD_PRESET)
                b.command = '0;
        end else if (roll < 68) begin
            b.action = ACT_BUTTON;
        end else begin
            b.action = ACT_TICK;
        end
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // present one beat and hold it until accepted; returns at a falling edge
    task automatic send_beat(input t_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        drv      <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        sb.set_reg(idx, d);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // drain, reconfigure while idle, then run a batch of random beats
    task automatic run_phase(input logic [GAIN_W-1:0] gain, input logic [WDOG_W-1:0] ticks,
                             input bit reverse, input int idle, input int stall,
                             input bit pressure);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_reg(CFG_DUTY_GAIN, CFG_DAT_W'(gain));
        write_reg(CFG_WATCHDOG_TICKS, CFG_DAT_W'(ticks));
        write_reg(CFG_COUNT_REVERSE, CFG_DAT_W'(reverse));
        send_idle_pct = idle;
        stall_pct     = stall;
        pressure_on   = pressure;
        repeat (PHASE_BEATS)
            send_beat(random_beat());
        pressure_on = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed beats at reset configuration
        send_beat(plain_beat(ACT_TICK));
        // first change records, then a walk down and back up
        send_beat(pin_beat(0, 1'b0, 1'b1));
        send_beat(pin_beat(0, 1'b1, 1'b1));
        send_beat(pin_beat(0, 1'b0, 1'b0));
        send_beat(pin_beat(0, 1'b1, 1'b0));
        send_beat(pin_beat(0, 1'b1, 1'b1));
        // same level again gives no step
        send_beat(pin_beat(0, 1'b1, 1'b1));
        // channels out of range
        send_beat(pin_beat(6, 1'b0, 1'b1));
        send_beat(pin_beat(7, 1'b1, 1'b1));
        send_beat(plain_beat(ACT_BUTTON));
        // preset near the wrap points, flag cleared
        send_beat(host_beat(HOST_CMD_PRESET, -16'sd1, 16'sd1, 16'sh5555,
                            16'sh7FFF, -16'sh8000, 16'sd0));
        send_beat(pin_beat(0, 1'b0, 1'b1));
        send_beat(pin_beat(1, 1'b0, 1'b1));
        send_beat(pin_beat(1, 1'b1, 1'b1));
        // duty saturation and other commands
        send_beat(host_beat(16'sd0, 16'sh7FFF, -16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
        send_beat(host_beat(-16'sh8000, 16'sd100, -16'sd100, 16'sd7,
                            16'sd0, 16'sd0, 16'sd0));
        send_beat(host_beat(16'sd2, -16'sd1, 16'sd1, 16'sd255, 16'sd0, 16'sd0, 16'sd0));
        send_beat(plain_beat(ACT_BUTTON));
        send_beat(plain_beat(ACT_TICK));
        send_beat(host_beat(HOST_CMD_PRESET, 16'sd0, 16'sd0, 16'sd0,
                            16'sd0, 16'sd0, 16'sd0));
        send_beat(pin_beat(5, 1'b1, 1'b1));
        send_beat(pin_beat(5, 1'b0, 1'b1));

        // random phases over gain, watchdog, direction and flow control
        run_phase(16'd2237, 20'd3, 1'b0, 0, 0, 1'b0);
        run_phase(16'hFFFF, 20'd1, 1'b1, 69, 0, 1'b0);
        run_phase(16'd0, 20'd0, 1'b0, 0, 69, 1'b0);
        run_phase(16'd1, 20'hFFFFF, 1'b1, 32, 32, 1'b0);
        run_phase(16'd256, 20'd12, 1'b1, 0, 0, 1'b1);
        run_phase(GAIN_W'($urandom), 20'($urandom_range(40, 2)), 1'($urandom), 32, 32, 1'b0);

        // wait for every expected result, then a few more cycles
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d beats, %0d results checked, %0d host messages",
                 beats_sent, sb.checked, sb.host_beats);
        $display("%0d watchdog expiries, %0d long result hold-offs, %0d mismatches",
                 sb.expiries, long_holds, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run time guard
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("FAILURE");
        $finish;
    end

endmodule
